FILE: rtl/qphs_pkg.sv
// ----------------------------------------------------------------------------
// qphs_pkg: shared types for the quadratic probe hash set
// Operation, status and slot codes, port widths, controller/datapath links.
// ----------------------------------------------------------------------------
package qphs_pkg;

    localparam int OPCODE_W     = 2;
    localparam int KEY_PORT_W   = 32;
    localparam int VALUE_PORT_W = 32;
    localparam int STATUS_W     = 2;
    localparam int SLOT_PORT_W  = 11;
    localparam int LIVE_PORT_W  = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_GET   = 2'd0,
        OP_SET   = 2'd1,
        OP_UNSET = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_LIVE    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_state_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic hash_step;
        logic rd;
        logic advance;
        logic resolve;
        logic sweep_step;
        logic load_out;
    } qphs_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic key_zero;
        logic hash_last;
        logic slot_empty;
        logic slot_hit;
        logic probe_last;
        logic sweep_last;
    } qphs_sts_t;

endpackage

FILE: rtl/quadratic_probe_hash_set_unit.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_set_unit: open-addressing key/value table
// Get, set, unset and clear on a prime-sized table with quadratic probing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (opcode, key, value) transfer on req_valid high and req_stall
//   low. Results (status, found_value, slot_index, live_entries) transfer on
//   rsp_valid high and rsp_stall low, one result per request, in order.
//   One request is in flight at a time; req_stall stays high until its
//   result sits in the output register.
//   Get, set and unset build the home slot remainder four key bits at a
//   time, then probe; each probe is one slot memory read followed by a
//   compare. With a zero key they return ST_INVALID without hashing or probing.
//   Clear sweeps the slot state memory one entry per cycle.
//   After reset the same sweep runs with req_stall high.
//   A stalled result holds in the output register; the next request is
//   taken meanwhile, and its result waits until the held one transfers.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_set_unit
    import qphs_pkg::*;
#(
    parameter int CAPACITY    = 1033,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [OPCODE_W-1:0]     opcode,
    input  logic [KEY_PORT_W-1:0]   key,
    input  logic [VALUE_PORT_W-1:0] value,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [VALUE_PORT_W-1:0] found_value,
    output logic [SLOT_PORT_W-1:0]  slot_index,
    output logic [LIVE_PORT_W-1:0]  live_entries
);

    qphs_cmd_t cmd;
    qphs_sts_t sts;

    qphs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    qphs_dp #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .key          (key),
        .value        (value),
        .status       (status),
        .found_value  (found_value),
        .slot_index   (slot_index),
        .live_entries (live_entries)
    );

`ifndef SYNTH
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted without stalling the next one");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ST_OK) |-> (slot_index == '0 && found_value == '0))
        else $error("failed operation reports a slot or a value");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(live_entries) <= 32'(CAPACITY / 2)))
        else $error("live count above half capacity");
`endif

endmodule

FILE: rtl/qphs_ram.sv
// ----------------------------------------------------------------------------
// qphs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qphs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/qphs_dp.sv
// ----------------------------------------------------------------------------
// qphs_dp: datapath of the quadratic probe hash set
// Home slot remainder, probe position, slot memories, live count, results.
// ----------------------------------------------------------------------------
module qphs_dp
    import qphs_pkg::*;
#(
    parameter int CAPACITY    = 1033,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qphs_cmd_t               cmd,
    output qphs_sts_t               sts,
    input  logic [OPCODE_W-1:0]     opcode,
    input  logic [KEY_PORT_W-1:0]   key,
    input  logic [VALUE_PORT_W-1:0] value,
    output logic [STATUS_W-1:0]     status,
    output logic [VALUE_PORT_W-1:0] found_value,
    output logic [SLOT_PORT_W-1:0]  slot_index,
    output logic [LIVE_PORT_W-1:0]  live_entries
);

    localparam int KW  = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
    localparam int VW  = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;
    localparam int DW  = KW + VW;
    localparam int IW  = $clog2(CAPACITY);
    localparam int W1  = IW + 1;
    localparam int ND  = (KW + 3) / 4;
    localparam int HW  = ND * 4;
    localparam int HCW = $clog2(ND);

    localparam logic [W1-1:0]  CAP_W1   = W1'(CAPACITY);
    localparam logic [IW-1:0]  CAP_LAST = IW'(CAPACITY - 1);
    localparam logic [IW-1:0]  HALF     = IW'(CAPACITY / 2);
    localparam logic [HCW-1:0] HC_LAST  = HCW'(ND - 1);

    op_t             op_reg;
    logic [KW-1:0]   key_reg;
    logic [VW-1:0]   value_reg;
    logic [HW-1:0]   sh_reg;
    logic [IW-1:0]   rem_reg;
    logic [HCW-1:0]  hcnt_reg;
    logic [IW-1:0]   pos_reg;
    logic [IW-1:0]   dmod_reg;
    logic [IW-1:0]   n_reg;
    logic [IW-1:0]   live_reg;
    logic [IW-1:0]   sweep_reg;
    status_t         res_status_reg;
    logic [VW-1:0]   res_fval_reg;
    logic [IW-1:0]   res_slot_reg;
    status_t         out_status_reg;
    logic [VW-1:0]   out_fval_reg;
    logic [IW-1:0]   out_slot_reg;
    logic [IW-1:0]   out_live_reg;

    logic [IW-1:0]   rem_next;
    logic [IW-1:0]   pos_next;
    logic [IW-1:0]   dmod_next;
    logic [IW-1:0]   live_next;
    status_t         res_status_next;
    logic [VW-1:0]   res_fval_next;
    logic [IW-1:0]   res_slot_next;

    logic [3:0]      digit;
    logic [W1-1:0]   pos_sum;
    logic [W1-1:0]   dmod_sum;

    logic            st_we;
    logic [IW-1:0]   st_waddr;
    logic [1:0]      st_wdata;
    logic [1:0]      st_rd;
    logic            dat_we;
    logic [DW-1:0]   dat_rd;

    assign digit = sh_reg[HW-1 -: 4];

    always_comb
    begin
        logic [W1-1:0] trial;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < 4; i++)
        begin
            trial = {rem_next, digit[3-i]};
            if (trial >= CAP_W1)
            begin
                trial = trial - CAP_W1;
            end
            rem_next = trial[IW-1:0];
        end
    end

    always_comb
    begin
        pos_sum  = {1'b0, pos_reg} + {1'b0, dmod_reg};
        dmod_sum = {1'b0, dmod_reg} + W1'(2);
        pos_next  = (pos_sum >= CAP_W1) ? IW'(pos_sum - CAP_W1) : pos_sum[IW-1:0];
        dmod_next = (dmod_sum >= CAP_W1) ? IW'(dmod_sum - CAP_W1) : dmod_sum[IW-1:0];
    end

    assign sts.is_clear   = (op_reg == OP_CLEAR);
    assign sts.key_zero   = (key_reg == '0);
    assign sts.hash_last  = (hcnt_reg == HC_LAST);
    assign sts.slot_empty = (st_rd == SLOT_EMPTY);
    assign sts.slot_hit   = (st_rd == SLOT_LIVE) && (dat_rd[DW-1:VW] == key_reg);
    assign sts.probe_last = (n_reg == CAP_LAST);
    assign sts.sweep_last = (sweep_reg == CAP_LAST);

    always_comb
    begin
        st_we           = 1'b0;
        st_waddr        = pos_reg;
        st_wdata        = SLOT_EMPTY;
        dat_we          = 1'b0;
        live_next       = live_reg;
        res_status_next = ST_OK;
        res_fval_next   = '0;
        res_slot_next   = '0;
        if (cmd.sweep_step)
        begin
            st_we    = 1'b1;
            st_waddr = sweep_reg;
        end
        if (cmd.decode)
        begin
            if (op_reg == OP_CLEAR)
            begin
                live_next = '0;
            end
            else if (key_reg == '0)
            begin
                res_status_next = ST_INVALID;
            end
        end
        if (cmd.resolve)
        begin
            case (op_reg)
                OP_GET:
                begin
                    if (sts.slot_hit)
                    begin
                        res_fval_next = dat_rd[VW-1:0];
                        res_slot_next = pos_reg;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
                OP_SET:
                begin
                    if (sts.slot_hit)
                    begin
                        dat_we        = 1'b1;
                        res_slot_next = pos_reg;
                    end
                    else if (!sts.slot_empty || live_reg >= HALF)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        st_we         = 1'b1;
                        st_wdata      = SLOT_LIVE;
                        dat_we        = 1'b1;
                        live_next     = live_reg + IW'(1);
                        res_slot_next = pos_reg;
                    end
                end
                OP_UNSET:
                begin
                    if (sts.slot_hit)
                    begin
                        st_we         = 1'b1;
                        st_wdata      = SLOT_DELETED;
                        res_slot_next = pos_reg;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - IW'(1);
                        end
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg  <= '0;
            n_reg     <= '0;
            live_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
            if (cmd.capture)
            begin
                hcnt_reg <= '0;
            end
            else if (cmd.hash_step)
            begin
                hcnt_reg <= hcnt_reg + HCW'(1);
                if (sts.hash_last)
                begin
                    n_reg <= '0;
                end
            end
            if (cmd.advance)
            begin
                n_reg <= n_reg + IW'(1);
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= sts.sweep_last ? '0 : sweep_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(opcode);
            key_reg   <= key[KW-1:0];
            value_reg <= value[VW-1:0];
            sh_reg    <= HW'(key[KW-1:0]);
            rem_reg   <= '0;
        end
        if (cmd.hash_step)
        begin
            sh_reg  <= sh_reg << 4;
            rem_reg <= rem_next;
            if (sts.hash_last)
            begin
                pos_reg  <= rem_next;
                dmod_reg <= IW'(1);
            end
        end
        if (cmd.advance)
        begin
            pos_reg  <= pos_next;
            dmod_reg <= dmod_next;
        end
        if (cmd.decode || cmd.resolve)
        begin
            res_status_reg <= res_status_next;
            res_fval_reg   <= res_fval_next;
            res_slot_reg   <= res_slot_next;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_fval_reg   <= res_fval_reg;
            out_slot_reg   <= res_slot_reg;
            out_live_reg   <= live_reg;
        end
    end

    qphs_ram #(
        .WIDTH (2),
        .DEPTH (CAPACITY)
    ) u_status_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_en   (cmd.rd),
        .rd_addr (pos_reg),
        .rd_data (st_rd)
    );

    qphs_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (dat_we),
        .wr_addr (pos_reg),
        .wr_data ({key_reg, value_reg}),
        .rd_en   (cmd.rd),
        .rd_addr (pos_reg),
        .rd_data (dat_rd)
    );

    assign status       = out_status_reg;
    assign found_value  = VALUE_PORT_W'(out_fval_reg);
    assign slot_index   = SLOT_PORT_W'(out_slot_reg);
    assign live_entries = LIVE_PORT_W'(out_live_reg);

endmodule

FILE: rtl/qphs_ctrl.sv
// ----------------------------------------------------------------------------
// qphs_ctrl: controller of the quadratic probe hash set
// Sequences capture, hashing, probing, clearing sweeps and result transfer.
// ----------------------------------------------------------------------------
module qphs_ctrl
    import qphs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  qphs_sts_t sts,
    output qphs_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_INIT_SWEEP,
        S_IDLE,
        S_DECODE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_CLR_SWEEP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_stall_reg;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.is_clear)
                begin
                    state_next = S_CLR_SWEEP;
                end
                else if (sts.key_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.slot_hit || sts.slot_empty || sts.probe_last)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_CLR_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT_SWEEP;
            req_stall_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_stall_reg <= (state_next != S_IDLE);
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = req_stall_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: dv/tb_quadratic_probe_hash_set_unit.sv
// ----------------------------------------------------------------------------
// tb_quadratic_probe_hash_set_unit: self-checking bench for the hash set unit
// Offers get, set, unset and clear requests on the valid/stall request port,
// predicts each result from a shadow copy of the slot table or, for typed
// directed rows, from the row itself, and compares each result transfer
// field by field. The run covers a directed table, churn on colliding keys,
// a fill to half load and a probe chain with no empty slot. Both ports idle
// at random, and the response port holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_hash_set_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import qphs_pkg::*;

    localparam int     SLOTS         = 1033;
    localparam int     HALF_LOAD     = SLOTS / 2;
    localparam int     CLK_HALF      = 6;
    localparam int     RST_CYCLES    = 11;
    localparam int     DRAIN_CYCLES  = 50;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     CHURN_ITEMS   = 60;
    localparam int     POOL_SIZE     = 12;
    localparam int     CHAIN_FIRST   = 400;
    localparam int     CHAIN_DROP    = 200;
    localparam longint TIMEOUT_NS    = 40_000_000;

    typedef struct packed {
        status_t                 status;
        logic [VALUE_PORT_W-1:0] found_value;
        logic [SLOT_PORT_W-1:0]  slot_index;
        logic [LIVE_PORT_W-1:0]  live_entries;
    } op_result_t;

    typedef struct packed {
        op_t                     op;
        logic [KEY_PORT_W-1:0]   key;
        logic [VALUE_PORT_W-1:0] value;
        logic                    typed;
        op_result_t              res;
    } directed_row_t;

    localparam directed_row_t DIRECTED_OPS [22] = '{
        '{OP_GET,   32'd1,         32'd0,         1'b1, '{ST_NOT_FOUND, 32'd0, 11'd0, 11'd0}},
        '{OP_SET,   32'd0,         32'hFFFF_FFFF, 1'b1, '{ST_INVALID, 32'd0, 11'd0, 11'd0}},
        '{OP_GET,   32'd0,         32'd0,         1'b1, '{ST_INVALID, 32'd0, 11'd0, 11'd0}},
        '{OP_UNSET, 32'd0,         32'd0,         1'b1, '{ST_INVALID, 32'd0, 11'd0, 11'd0}},
        '{OP_SET,   32'd5,         32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'd0, 11'd5, 11'd1}},
        '{OP_GET,   32'd5,         32'd0,         1'b1, '{ST_OK, 32'hFFFF_FFFF, 11'd5, 11'd1}},
        '{OP_SET,   32'd1038,      32'd0,         1'b0, '0},
        '{OP_SET,   32'd2071,      32'h5A5A_5A5A, 1'b0, '0},
        '{OP_SET,   32'hFFFF_FFFF, 32'h1234_5678, 1'b0, '0},
        '{OP_GET,   32'hFFFF_FFFF, 32'd0,         1'b0, '0},
        '{OP_UNSET, 32'd1038,      32'd0,         1'b0, '0},
        '{OP_GET,   32'd2071,      32'hFFFF_FFFF, 1'b0, '0},
        '{OP_SET,   32'd1038,      32'hA5A5_A5A5, 1'b0, '0},
        '{OP_UNSET, 32'd7,         32'd0,         1'b0, '0},
        '{OP_SET,   32'd5,         32'd0,         1'b0, '0},
        '{OP_SET,   32'd1032,      32'h8000_0000, 1'b0, '0},
        '{OP_SET,   32'd2065,      32'd1,         1'b0, '0},
        '{OP_CLEAR, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'd0, 11'd0, 11'd0}},
        '{OP_GET,   32'd5,         32'd0,         1'b1, '{ST_NOT_FOUND, 32'd0, 11'd0, 11'd0}},
        '{OP_SET,   32'h8000_0000, 32'hC3C3_C3C3, 1'b0, '0},
        '{OP_CLEAR, 32'd0,         32'd0,         1'b1, '{ST_OK, 32'd0, 11'd0, 11'd0}},
        '{OP_UNSET, 32'd1,         32'd0,         1'b1, '{ST_NOT_FOUND, 32'd0, 11'd0, 11'd0}}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_stall;
    logic [OPCODE_W-1:0]     opcode;
    logic [KEY_PORT_W-1:0]   key;
    logic [VALUE_PORT_W-1:0] value;
    logic                    rsp_valid;
    logic                    rsp_stall;
    logic [STATUS_W-1:0]     status;
    logic [VALUE_PORT_W-1:0] found_value;
    logic [SLOT_PORT_W-1:0]  slot_index;
    logic [LIVE_PORT_W-1:0]  live_entries;

    slot_state_t             shadow_state [SLOTS];
    logic [KEY_PORT_W-1:0]   shadow_key   [SLOTS];
    logic [VALUE_PORT_W-1:0] shadow_value [SLOTS];
    int unsigned             shadow_live;
    op_result_t              pending_results [$];
    int unsigned             error_count;
    bit                      calm;
    bit                      hold_request;

    quadratic_probe_hash_set_unit #(
        .CAPACITY    (SLOTS),
        .KEY_WIDTH   (KEY_PORT_W),
        .VALUE_WIDTH (VALUE_PORT_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .key          (key),
        .value        (value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .found_value  (found_value),
        .slot_index   (slot_index),
        .live_entries (live_entries)
    );

    function automatic void wipe_shadow();
        foreach (shadow_state[i])
            shadow_state[i] = SLOT_EMPTY;
        shadow_live = 0;
    endfunction

    function automatic bit find_slot(input logic [KEY_PORT_W-1:0] k, output int pos);
        int p;
        int stride;
        p = int'(k % 32'(SLOTS));
        stride = 1;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (shadow_state[p] == SLOT_EMPTY)
            begin
                pos = p;
                return 1'b0;
            end
            if (shadow_state[p] == SLOT_LIVE && shadow_key[p] == k)
            begin
                pos = p;
                return 1'b1;
            end
            p = (p + stride % SLOTS) % SLOTS;
            stride += 2;
        end
        pos = SLOTS;
        return 1'b0;
    endfunction

    function automatic op_result_t apply_request(input op_t op,
                                                 input logic [KEY_PORT_W-1:0] k,
                                                 input logic [VALUE_PORT_W-1:0] v);
        op_result_t r;
        int         pos;
        bit         hit;
        r = '0;
        r.status = ST_OK;
        if (op == OP_CLEAR)
            wipe_shadow();
        else if (k == '0)
            r.status = ST_INVALID;
        else
        begin
            hit = find_slot(k, pos);
            case (op)
                OP_GET:
                    if (hit)
                    begin
                        r.found_value = shadow_value[pos];
                        r.slot_index  = SLOT_PORT_W'(pos);
                    end
                    else
                        r.status = ST_NOT_FOUND;
                OP_SET:
                    if (hit)
                    begin
                        shadow_value[pos] = v;
                        r.slot_index      = SLOT_PORT_W'(pos);
                    end
                    else if (pos >= SLOTS || shadow_live >= HALF_LOAD)
                        r.status = ST_FULL;
                    else
                    begin
                        shadow_state[pos] = SLOT_LIVE;
                        shadow_key[pos]   = k;
                        shadow_value[pos] = v;
                        shadow_live++;
                        r.slot_index      = SLOT_PORT_W'(pos);
                    end
                default:
                    if (hit)
                    begin
                        shadow_state[pos] = SLOT_DELETED;
                        if (shadow_live > 0)
                            shadow_live--;
                        r.slot_index = SLOT_PORT_W'(pos);
                    end
                    else
                        r.status = ST_NOT_FOUND;
            endcase
        end
        r.live_entries = LIVE_PORT_W'(shadow_live);
        return r;
    endfunction

    // hold the payload until the transfer, then record the predicted result
    task automatic offer(input op_t op, input logic [KEY_PORT_W-1:0] k,
                         input logic [VALUE_PORT_W-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        key       <= k;
        value     <= v;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        pending_results.push_back(apply_request(op, k, v));
    endtask

    // clear, then mix operations over a few keys that share home slots, plus zero and random keys
    task automatic churn_colliding_keys(input int items);
        logic [KEY_PORT_W-1:0] pool [POOL_SIZE];
        logic [KEY_PORT_W-1:0] k;
        int unsigned           home;
        int unsigned           roll;
        op_t                   op;
        home = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i % 4 == 0)
                home = ($urandom_range(0, 3) == 0) ? $urandom_range(SLOTS - 13, SLOTS - 1)
                                                   : $urandom_range(0, SLOTS - 1);
            pool[i] = 32'(home + 32'(SLOTS) * $urandom_range(0, 4_157_000));
        end
        offer(OP_CLEAR, $urandom, $urandom);
        for (int i = 0; i < items; i++)
        begin
            roll = $urandom_range(0, 99);
            k = pool[$urandom_range(0, POOL_SIZE - 1)];
            if (roll < 5)
                k = '0;
            else if (roll < 12)
                k = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 35)
                op = OP_SET;
            else if (roll < 65)
                op = OP_GET;
            else if (roll < 97)
                op = OP_UNSET;
            else
                op = OP_CLEAR;
            offer(op, k, $urandom);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("** quadratic_probe_hash_set_unit: FAILED **");
        $finish;
    end

    initial
    begin : response_stall
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (calm)
            begin
                rsp_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        op_result_t want;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing pending: status %0d slot %0d",
                       status, slot_index);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (found_value !== want.found_value)
                begin
                    $error("found_value: expected %h, got %h", want.found_value, found_value);
                    error_count++;
                end
                if (slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
                    error_count++;
                end
                if (live_entries !== want.live_entries)
                begin
                    $error("live_entries: expected %0d, got %0d",
                           want.live_entries, live_entries);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [KEY_PORT_W-1:0] filled [$];
        logic [KEY_PORT_W-1:0] k;
        int unsigned           home;
        int unsigned           off;
        req_valid    <= 1'b0;
        opcode       <= OP_GET;
        key          <= '0;
        value        <= '0;
        error_count  = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        wipe_shadow();
        while (rst_n !== 1'b1)
            @(posedge clk);

        foreach (DIRECTED_OPS[i])
        begin
            offer(DIRECTED_OPS[i].op, DIRECTED_OPS[i].key, DIRECTED_OPS[i].value);
            if (DIRECTED_OPS[i].typed)
                pending_results[pending_results.size() - 1] = DIRECTED_OPS[i].res;
        end

        hold_request = 1'b1;
        repeat (3) churn_colliding_keys(CHURN_ITEMS);

        // fill to half load, then probe the refusal and update paths
        offer(OP_CLEAR, $urandom, $urandom);
        while (shadow_live < HALF_LOAD)
        begin
            if (filled.size() > 0 && $urandom_range(0, 7) == 0)
                offer(OP_GET, filled[$urandom_range(0, filled.size() - 1)], $urandom);
            else
            begin
                k = $urandom;
                filled.push_back(k);
                offer(OP_SET, k, $urandom);
            end
        end
        offer(OP_SET, $urandom | 32'd1, $urandom);
        offer(OP_SET, filled[0], $urandom);
        offer(OP_UNSET, filled[1], $urandom);
        offer(OP_SET, $urandom | 32'd1, $urandom);
        offer(OP_SET, $urandom | 32'd1, $urandom);
        repeat (20)
        begin
            k = ($urandom_range(0, 1) == 0) ? filled[$urandom_range(0, filled.size() - 1)]
                                            : $urandom;
            offer(OP_GET, k, $urandom);
        end

        repeat (2) churn_colliding_keys(CHURN_ITEMS);

        // occupy every slot of one probe chain with live or deleted keys
        offer(OP_CLEAR, $urandom, $urandom);
        home = $urandom_range(0, SLOTS - 1);
        off  = $urandom_range(1, 4_000_000);
        for (int i = 0; i < CHAIN_FIRST; i++)
            offer(OP_SET, 32'(home + 32'(SLOTS) * (off + i)), $urandom);
        for (int i = 0; i < CHAIN_DROP; i++)
            offer(OP_UNSET, 32'(home + 32'(SLOTS) * (off + i)), $urandom);
        for (int i = CHAIN_FIRST; i <= HALF_LOAD; i++)
            offer(OP_SET, 32'(home + 32'(SLOTS) * (off + i)), $urandom);
        offer(OP_GET, 32'(home + 32'(SLOTS) * (off + 600)), $urandom);
        offer(OP_SET, 32'(home + 32'(SLOTS) * (off + 601)), $urandom);
        offer(OP_GET, 32'(home + 32'(SLOTS) * (off + HALF_LOAD)), $urandom);
        offer(OP_UNSET, 32'(home + 32'(SLOTS) * (off + 450)), $urandom);
        offer(OP_SET, 32'(home + 32'(SLOTS) * (off + 602)), $urandom);
        offer(OP_GET, 32'(home + 32'(SLOTS) * (off + 100)), $urandom);
        offer(OP_SET, 32'(home + 32'(SLOTS) * (off + 300)), $urandom);

        repeat (2) churn_colliding_keys(CHURN_ITEMS);

        calm = 1'b1;
        repeat (3) churn_colliding_keys(CHURN_ITEMS);

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** quadratic_probe_hash_set_unit: PASSED **");
        else
            $display("** quadratic_probe_hash_set_unit: FAILED **");
        $finish;
    end

endmodule
